@@ src/lsp_pkg.sv @@
// ----------------------------------------------------------------------------
// lsp_pkg: shared constants for the line steering and wheel speed controller
// Fixed-point widths, Q0.16 constants, time-step reciprocal and register codes.
// ----------------------------------------------------------------------------
package lsp_pkg;

  // number formats
  localparam int FRAC_BITS   = 16;
  localparam int SENSOR_BITS = 12;
  localparam int SENS_UP     = FRAC_BITS - SENSOR_BITS;
  localparam int GAIN_W      = 20;
  localparam int DIV_W       = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int OUT_W       = 16;
  localparam int ERR_W       = FRAC_BITS + 2;   // sensor difference
  localparam int AREA_W      = FRAC_BITS + 4;   // integrator, +-4.0
  localparam int DE_W        = 28;              // error step times 1000
  localparam int MA_W        = GAIN_W + 1;      // gain side of the multiplier
  localparam int MB_W        = DE_W;            // signal side of the multiplier
  localparam int PROD_W      = MA_W + MB_W;
  localparam int ACC_W       = PROD_W + 1;
  localparam int RND_W       = ACC_W - FRAC_BITS;

  // Q0.16 constants and the integrator limit in signed Q.16
  localparam logic [OUT_W-1:0] Q_BIAS     = 16'd4915;   // 0.075
  localparam logic [OUT_W-1:0] Q_SERVO_LO = 16'd3277;   // 0.05
  localparam logic [OUT_W-1:0] Q_SERVO_HI = 16'd6554;   // 0.10
  localparam logic [OUT_W-1:0] Q_SPAN     = 16'd1638;   // 0.025
  localparam logic [OUT_W-1:0] Q_TGT_LO   = 16'd16384;  // 0.25
  localparam logic [OUT_W-1:0] Q_TGT_HI   = 16'd49152;  // 0.75
  localparam logic [OUT_W-1:0] Q_DUTY_LO  = 16'd13107;  // 0.2
  localparam logic [OUT_W-1:0] Q_DUTY_HI  = 16'd55706;  // 0.85
  localparam logic [OUT_W-1:0] Q_HALF     = 16'd32768;  // 0.5
  localparam logic signed [AREA_W:0] AREA_LIM = 21'sd262144;  // 4.0

  // divide by 1000 as a multiply by ceil(2^28/1000) and a shift
  localparam logic [18:0] RECIP_TI    = 19'd268436;
  localparam int          RECIP_SHIFT = 28;
  localparam int          TI_Q_W      = 8;
  localparam logic [16:0] TI_ROUND    = 17'd500;
  localparam logic [MA_W-1:0] DERIV_SCALE = 21'd1000;

  // register codes
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEER_KI = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_KP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_KI = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_DIV = 3'd5;

  typedef logic [GAIN_W-1:0] gain_t;

endpackage

@@ src/line_steer_pid_with_wheel_speed_pi.sv @@
// ----------------------------------------------------------------------------
// line_steer_pid_with_wheel_speed_pi: line steering PID with wheel speed PI
// One request per control tick: a steering PID on the line sensors drives the
// servo duty and a speed setpoint, and every motor_divide ticks two wheel PI
// loops refresh the motor duties. All products go through one multiplier.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  cfg      in         cfg_write            cfg_index, cfg_data
//  in       in         in_valid / in_stall  run, left_line, right_line,
//                                           left_speed, right_speed
//  out      out        out_valid / out_stall servo_duty, left_duty,
//                                           right_duty, speed_target
//
//  an idle request (run clear) goes straight to the output step; a running
//  request passes the steering steps, and a wheel update adds the wheel
//  steps for both sides; each product uses the single shared 21x28 multiplier.
//  in_stall is high from acceptance until the result is loaded into the
//  output register; a stalled output holds the sequencer in its final step
//  rst is synchronous and restores the register defaults and loop state
//
module line_steer_pid_with_wheel_speed_pi
  import lsp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [GAIN_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   run,
  input  logic [SENSOR_BITS-1:0] left_line,
  input  logic [SENSOR_BITS-1:0] right_line,
  input  logic [SENSOR_BITS-1:0] left_speed,
  input  logic [SENSOR_BITS-1:0] right_speed,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [OUT_W-1:0]       servo_duty,
  output logic [OUT_W-1:0]       left_duty,
  output logic [OUT_W-1:0]       right_duty,
  output logic [OUT_W-1:0]       speed_target
);

  // sequencer steps
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DE     = 4'd1;   // issue 1000 * error step
  localparam logic [3:0] ST_STI    = 4'd2;   // issue steering error / 1000
  localparam logic [3:0] ST_SKD    = 4'd3;   // steering area update, issue kd
  localparam logic [3:0] ST_SKP    = 4'd4;   // issue kp
  localparam logic [3:0] ST_SKI    = 4'd5;   // issue ki
  localparam logic [3:0] ST_SACC   = 4'd6;   // last accumulate
  localparam logic [3:0] ST_SERVO  = 4'd7;   // round, bias, clamp servo duty
  localparam logic [3:0] ST_TARGET = 4'd8;   // speed setpoint and divider
  localparam logic [3:0] ST_WTI    = 4'd9;   // issue wheel error / 1000
  localparam logic [3:0] ST_WKP    = 4'd10;  // wheel area update, issue kp
  localparam logic [3:0] ST_WKI    = 4'd11;  // issue ki
  localparam logic [3:0] ST_WACC   = 4'd12;  // last accumulate
  localparam logic [3:0] ST_WDUTY  = 4'd13;  // round and clamp wheel duty
  localparam logic [3:0] ST_DONE   = 4'd14;  // load the output register

  localparam logic signed [ACC_W-1:0] RND_POS = ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] RND_NEG = ACC_W'(32767);

  // control and loop state
  logic [3:0]   state;
  logic         side;          // 0 left wheel, 1 right wheel
  gain_t        steer_kp, steer_kd, steer_ki, wheel_kp, wheel_ki;
  logic [DIV_W-1:0] motor_divide;
  logic signed [ERR_W-1:0]  last_err;
  logic signed [AREA_W-1:0] steer_area, left_area, right_area;
  logic [OUT_W-1:0] held_target, held_left, held_right;
  logic [DIV_W-1:0] tick_count;
  logic         first_update;

  // per-request working registers
  logic         run_r;
  logic signed [ERR_W-1:0] err;
  logic [SENSOR_BITS-1:0]  lspd, rspd;
  logic signed [DE_W-1:0]  de_reg;
  logic [OUT_W-1:0]        servo_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // datapath wires
  logic [FRAC_BITS-1:0]    left_q, right_q, spd_q;
  logic signed [ERR_W-1:0] err_next, werr;
  logic signed [ERR_W:0]   diff;
  logic signed [MA_W-1:0]  ma;
  logic signed [MB_W-1:0]  mb;
  logic [TI_Q_W-1:0]       ti_q;
  logic signed [ACC_W-1:0] acc_biased;
  logic signed [RND_W-1:0] rnd;
  logic [OUT_W-1:0]        dev;
  logic [OUT_W-1:0]        duty;
  logic [DIV_W:0]          tick_inc;
  logic                    wheel_due;
  logic                    load_out;

  // |v| + 500, the rounded divide argument
  function automatic logic [16:0] ti_arg(input logic signed [ERR_W-1:0] v);
    logic [ERR_W-1:0] m;
    m = v[ERR_W-1] ? ERR_W'(-v) : ERR_W'(v);
    return m[16:0] + TI_ROUND;
  endfunction

  // integrator step with saturation at +-4.0
  function automatic logic signed [AREA_W-1:0] area_step(
    input logic signed [AREA_W-1:0] area,
    input logic [TI_Q_W-1:0]        q,
    input logic                     neg
  );
    logic signed [AREA_W:0] dq;
    logic signed [AREA_W:0] s;
    dq = $signed({{(AREA_W + 1 - TI_Q_W){1'b0}}, q});
    s  = {area[AREA_W-1], area} + (neg ? -dq : dq);
    if (s <= -AREA_LIM) begin
      return AREA_W'(-AREA_LIM);
    end else if (s >= AREA_LIM) begin
      return AREA_W'(AREA_LIM);
    end
    return s[AREA_W-1:0];
  endfunction

  // clamp to an unsigned range, bounds inclusive
  function automatic logic [OUT_W-1:0] clamp16(
    input logic signed [RND_W-1:0] v,
    input logic [OUT_W-1:0]        lo,
    input logic [OUT_W-1:0]        hi
  );
    if (v <= $signed({{(RND_W - OUT_W){1'b0}}, lo})) begin
      return lo;
    end else if (v >= $signed({{(RND_W - OUT_W){1'b0}}, hi})) begin
      return hi;
    end
    return v[OUT_W-1:0];
  endfunction

  // sensors rescaled to Q.16
  assign left_q   = {left_line,  {SENS_UP{1'b0}}};
  assign right_q  = {right_line, {SENS_UP{1'b0}}};
  assign spd_q    = side ? {rspd, {SENS_UP{1'b0}}} : {lspd, {SENS_UP{1'b0}}};
  assign err_next = $signed({2'b00, right_q}) - $signed({2'b00, left_q});
  assign werr     = $signed({2'b00, held_target}) - $signed({2'b00, spd_q});
  assign diff     = {err[ERR_W-1], err} - {last_err[ERR_W-1], last_err};

  // quotient of the divide by 1000
  assign ti_q = prod[RECIP_SHIFT+TI_Q_W-1:RECIP_SHIFT];

  // round half away from zero on the >>16 of the accumulator
  assign acc_biased = acc + (acc[ACC_W-1] ? RND_NEG : RND_POS);
  assign rnd        = acc_biased[ACC_W-1:FRAC_BITS];

  assign dev = (servo_q >= Q_BIAS) ? (servo_q - Q_BIAS) : (Q_BIAS - servo_q);

  // first wheel update forces both duties to one half
  assign duty = first_update ? Q_HALF : clamp16(rnd, Q_DUTY_LO, Q_DUTY_HI);

  assign tick_inc  = {1'b0, tick_count} + (DIV_W + 1)'(1);
  assign wheel_due = tick_inc >= {1'b0, motor_divide};

  assign in_stall = (state != ST_IDLE);
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  // operand selection for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_DE: begin
        ma = $signed(DERIV_SCALE);
        mb = MB_W'(diff);
      end
      ST_STI: begin
        ma = $signed({2'b00, RECIP_TI});
        mb = $signed({{(MB_W - 17){1'b0}}, ti_arg(err)});
      end
      ST_SKD: begin
        ma = $signed({1'b0, steer_kd});
        mb = de_reg;
      end
      ST_SKP: begin
        ma = $signed({1'b0, steer_kp});
        mb = MB_W'(err);
      end
      ST_SKI: begin
        ma = $signed({1'b0, steer_ki});
        mb = MB_W'(steer_area);
      end
      ST_WTI: begin
        ma = $signed({2'b00, RECIP_TI});
        mb = $signed({{(MB_W - 17){1'b0}}, ti_arg(werr)});
      end
      ST_WKP: begin
        ma = $signed({1'b0, wheel_kp});
        mb = MB_W'(werr);
      end
      ST_WKI: begin
        ma = $signed({1'b0, wheel_ki});
        mb = side ? MB_W'(right_area) : MB_W'(left_area);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      steer_kp     <= gain_t'(8192);
      steer_kd     <= '0;
      steer_ki     <= gain_t'(3277);
      wheel_kp     <= gain_t'(65536);
      wheel_ki     <= gain_t'(32768);
      motor_divide <= DIV_W'(100);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STEER_KP:  steer_kp     <= cfg_data;
        REG_STEER_KD:  steer_kd     <= cfg_data;
        REG_STEER_KI:  steer_ki     <= cfg_data;
        REG_WHEEL_KP:  wheel_kp     <= cfg_data;
        REG_WHEEL_KI:  wheel_ki     <= cfg_data;
        REG_MOTOR_DIV: motor_divide <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      side         <= 1'b0;
      out_valid    <= 1'b0;
      last_err     <= '0;
      steer_area   <= '0;
      left_area    <= '0;
      right_area   <= '0;
      held_target  <= Q_HALF;
      held_left    <= '0;
      held_right   <= '0;
      tick_count   <= '0;
      first_update <= 1'b1;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= run ? ST_DE : ST_DONE;
          end
        end
        ST_DE:   state <= ST_STI;
        ST_STI:  state <= ST_SKD;
        ST_SKD: begin
          steer_area <= area_step(steer_area, ti_q, err[ERR_W-1]);
          state      <= ST_SKP;
        end
        ST_SKP:  state <= ST_SKI;
        ST_SKI:  state <= ST_SACC;
        ST_SACC: state <= ST_SERVO;
        ST_SERVO: begin
          last_err <= err;
          state    <= ST_TARGET;
        end
        ST_TARGET: begin
          // setpoint 16 * (0.025 - |u - 0.075|), lower bound dominates
          held_target <= clamp16(
            ($signed({{(RND_W - OUT_W){1'b0}}, Q_SPAN})
             - $signed({{(RND_W - OUT_W){1'b0}}, dev})) <<< 4,
            Q_TGT_LO, Q_TGT_HI);
          side <= 1'b0;
          if (wheel_due) begin
            tick_count <= '0;
            state      <= ST_WTI;
          end else begin
            tick_count <= tick_inc[DIV_W-1:0];
            state      <= ST_DONE;
          end
        end
        ST_WTI:  state <= ST_WKP;
        ST_WKP: begin
          if (side) begin
            right_area <= area_step(right_area, ti_q, werr[ERR_W-1]);
          end else begin
            left_area  <= area_step(left_area, ti_q, werr[ERR_W-1]);
          end
          state <= ST_WKI;
        end
        ST_WKI:  state <= ST_WACC;
        ST_WACC: state <= ST_WDUTY;
        ST_WDUTY: begin
          if (side) begin
            held_right   <= duty;
            first_update <= 1'b0;
            state        <= ST_DONE;
          end else begin
            held_left <= duty;
            side      <= 1'b1;
            state     <= ST_WTI;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (state == ST_IDLE && in_valid) begin
      run_r <= run;
      err   <= err_next;
      lspd  <= left_speed;
      rspd  <= right_speed;
    end
    unique case (state)
      ST_STI:            de_reg <= prod[DE_W-1:0];
      ST_SKP, ST_WKI:    acc    <= {prod[PROD_W-1], prod};
      ST_SKI, ST_SACC,
      ST_WACC:           acc    <= acc + {prod[PROD_W-1], prod};
      ST_SERVO:          servo_q <= clamp16(
                           rnd + $signed({{(RND_W - OUT_W){1'b0}}, Q_BIAS}),
                           Q_SERVO_LO, Q_SERVO_HI);
      default: ;
    endcase
    if (load_out) begin
      servo_duty   <= run_r ? servo_q    : Q_BIAS;
      left_duty    <= run_r ? held_left  : '0;
      right_duty   <= run_r ? held_right : '0;
      speed_target <= held_target;
    end
  end

endmodule
